// ===== hw/rtl/ecr_pkg.sv =====
package ecr_pkg;

    localparam int LETTERS         = 26;
    localparam int LETTER_W        = 5;
    localparam int KIND_W          = 3;
    localparam int SEL_W           = 3;
    localparam int CNT_W           = 4;
    localparam int DEF_MAX_ROTORS  = 8;

    typedef logic [LETTER_W-1:0] t_letter;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ENC    = 3'd0,
        KIND_WIRE   = 3'd1,
        KIND_NOTCH  = 3'd2,
        KIND_PLUG   = 3'd3,
        KIND_REFL   = 3'd4,
        KIND_OFFSET = 3'd5
    } t_kind;

    // Load operations on the rotor offset / notch file
    typedef enum logic [1:0] {
        RS_NONE,
        RS_OFFSET,
        RS_NOTCH
    } t_rs_op;

    typedef struct packed {
        t_rs_op           op;
        logic [SEL_W-1:0] sel;
        t_letter          pos;
        t_letter          val;
        logic             flag;
    } t_rs_load;

    // (a + b) mod 26 for letters
    function automatic t_letter letter_add(input t_letter a, input t_letter b);
        logic [LETTER_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (LETTER_W+1)'(LETTERS)) begin
            s = s - (LETTER_W+1)'(LETTERS);
        end
        return s[LETTER_W-1:0];
    endfunction

    // (w - k) mod 26 for letters
    function automatic t_letter letter_sub(input t_letter w, input t_letter k);
        t_letter d;
        if (w >= k) begin
            d = w - k;
        end else begin
            d = w + LETTER_W'(LETTERS) - k;
        end
        return d;
    endfunction

    // Fold a 5-bit value into 0..25
    function automatic t_letter letter_mod(input t_letter p);
        t_letter m;
        if (p >= LETTER_W'(LETTERS)) begin
            m = p - LETTER_W'(LETTERS);
        end else begin
            m = p;
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/ecr_rotor_mem.sv =====
module ecr_rotor_mem import ecr_pkg::*; #(
    parameter int MAX_ROTORS = DEF_MAX_ROTORS,
    localparam int DEPTH     = MAX_ROTORS * LETTERS,
    localparam int AW        = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_fwd_waddr,
    input  t_letter       i_fwd_wdata,
    input  logic [AW-1:0] i_rev_waddr,
    input  t_letter       i_rev_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_letter       o_fwd_rdata,
    output t_letter       o_rev_rdata
);

    t_letter r_fwd_mem [DEPTH];
    t_letter r_rev_mem [DEPTH];
    t_letter r_fwd_q;
    t_letter r_rev_q;

    // Forward wiring and its inverse share the read address; hold data when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_fwd_mem[i_fwd_waddr] <= i_fwd_wdata;
        end
        if (i_re) begin
            r_fwd_q <= r_fwd_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_rev_mem[i_rev_waddr] <= i_rev_wdata;
        end
        if (i_re) begin
            r_rev_q <= r_rev_mem[i_raddr];
        end
    end

    assign o_fwd_rdata = r_fwd_q;
    assign o_rev_rdata = r_rev_q;

endmodule

// ===== hw/rtl/ecr_rotor_state.sv =====
module ecr_rotor_state import ecr_pkg::*; #(
    parameter int MAX_ROTORS = DEF_MAX_ROTORS,
    localparam int IDX_W     = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_rs_load         i_load,
    input  logic             i_step_en,
    input  logic [IDX_W-1:0] i_step_idx,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_letter          o_offset,
    output logic             o_notch_hit
);

    t_letter           r_offset [MAX_ROTORS];
    logic [LETTERS-1:0] r_notch [MAX_ROTORS];

    logic [IDX_W-1:0] w_load_idx;
    assign w_load_idx = IDX_W'(i_load.sel);

    for (genvar g = 0; g < MAX_ROTORS; g++) begin : g_rotor
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_offset[g] <= '0;
                r_notch[g]  <= '0;
            end else begin
                if (i_load.op == RS_OFFSET && w_load_idx == IDX_W'(g)) begin
                    r_offset[g] <= i_load.val;
                end
                if (i_load.op == RS_NOTCH && w_load_idx == IDX_W'(g)) begin
                    r_notch[g][i_load.pos] <= i_load.flag;
                end
                // advance one letter
                if (i_step_en && i_step_idx == IDX_W'(g)) begin
                    r_offset[g] <= letter_add(r_offset[g], LETTER_W'(1));
                end
            end
        end
    end

    assign o_offset    = r_offset[i_rd_idx];
    assign o_notch_hit = r_notch[i_rd_idx][o_offset];

endmodule

// ===== hw/rtl/enigma_rotor_cipher.sv =====
// Enigma-style rotor cipher on letters 0..25 (0 is A). Each input item is either a load or
// a letter to encipher (kind 0). Loads give no result: wiring loads write a rotor's forward
// entry and its inverse entry, notch loads set or clear one notch, plugboard and reflector
// loads write a letter pair, offset loads set a rotor's position. Out-of-range loads are
// dropped. An enciphered letter goes through the plugboard, steps rotor 0 and cascades the
// stepping through the notches, passes forward through the rotors in use, the reflector,
// back through the inverse wirings and the plugboard again. Both wirings live in a
// synchronous memory with a registered read; the pass reads one rotor per cycle, each read
// address depending on the letter that the previous read returned. With the rotors in use
// (rotor_count, 0 read as 1, clamped to MAX_ROTORS) a letter goes from acceptance to its
// result through the plugboard state, which also steps rotor 0, the notch cascade, the issue
// of the first rotor read and the forward and inverse reads. The input is ready again once
// the result is written, and one item is worked at a time. The result waits in an output
// register; loads are still taken while it waits, and a following letter stalls at its last
// step until the register is free. rotor_count must be written only while the block is idle;
// the block does not enforce this. Reset gives offsets of zero, no notches and an identity
// plugboard; rotor wirings and the reflector must be loaded before use.
module enigma_rotor_cipher import ecr_pkg::*; #(
    parameter int MAX_ROTORS = DEF_MAX_ROTORS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    // input items
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [2:0]       i_kind,
    input  logic [2:0]       i_rotor_sel,
    input  logic [4:0]       i_position,
    input  logic [4:0]       i_entry_value,
    input  logic             i_notch_flag,
    // result items
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [4:0]       o_cipher_letter
);

    localparam int IDX_W = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
    localparam int DEPTH = MAX_ROTORS * LETTERS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLUG,
        ST_CASC,
        ST_ISSUE,
        ST_PASS
    } t_state;

    typedef enum logic {
        DIR_FWD,
        DIR_REV
    } t_dir;

    t_state           r_state, n_state;
    t_letter          r_x, n_x;
    logic [IDX_W-1:0] r_j, n_j;
    t_letter          r_k, n_k;
    t_dir             r_dir, n_dir;
    logic             r_out_valid, n_out_valid;
    t_letter          r_out_letter, n_out_letter;
    logic [CNT_W-1:0] r_rotor_count;

    t_letter r_plug [LETTERS];
    t_letter r_refl [LETTERS];

    logic             w_in_acc;
    t_kind            w_kind;
    logic             w_sel_ok, w_pos_ok, w_val_ok;
    logic [IDX_W-1:0] w_last_idx;

    // rotor pass issue
    logic             w_iss;
    logic [IDX_W-1:0] w_iss_idx;
    t_letter          w_iss_x;
    t_dir             w_iss_dir;
    logic [IDX_W-1:0] w_rd_idx;
    t_letter          w_offset;
    logic             w_hit;
    logic             w_step_en;
    logic [IDX_W-1:0] w_step_idx;
    logic [AW-1:0]    w_raddr;
    t_letter          w_fwd_rdata, w_rev_rdata, w_rdata;
    t_letter          w_x_t;
    t_letter          w_plug_idx, w_plug_out;

    // loads
    t_rs_load         w_rs_load;
    logic             w_wire_we;
    logic             w_plug_we, w_refl_we;
    logic [AW-1:0]    w_fwd_waddr, w_rev_waddr;

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_kind   = t_kind'(i_kind);
    assign w_sel_ok = 32'(i_rotor_sel) < MAX_ROTORS;
    assign w_pos_ok = i_position < LETTER_W'(LETTERS);
    assign w_val_ok = i_entry_value < LETTER_W'(LETTERS);

    // rotors in use, as the index of the last one
    always_comb begin
        if (r_rotor_count == '0) begin
            w_last_idx = '0;
        end else if (32'(r_rotor_count) >= MAX_ROTORS) begin
            w_last_idx = IDX_W'(MAX_ROTORS - 1);
        end else begin
            w_last_idx = IDX_W'(r_rotor_count - CNT_W'(1));
        end
    end

    // Decode loads; they are only accepted in idle
    always_comb begin
        w_rs_load.op   = RS_NONE;
        w_rs_load.sel  = i_rotor_sel;
        w_rs_load.pos  = i_position;
        w_rs_load.val  = i_entry_value;
        w_rs_load.flag = i_notch_flag;
        w_wire_we      = 1'b0;
        w_plug_we      = 1'b0;
        w_refl_we      = 1'b0;
        if (w_in_acc) begin
            case (w_kind)
                KIND_WIRE: begin
                    w_wire_we = w_sel_ok && w_pos_ok && w_val_ok;
                end
                KIND_NOTCH: begin
                    if (w_sel_ok && w_pos_ok) begin
                        w_rs_load.op = RS_NOTCH;
                    end
                end
                KIND_PLUG: begin
                    w_plug_we = w_pos_ok && w_val_ok;
                end
                KIND_REFL: begin
                    w_refl_we = w_pos_ok && w_val_ok;
                end
                KIND_OFFSET: begin
                    if (w_sel_ok && w_val_ok) begin
                        w_rs_load.op = RS_OFFSET;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_fwd_waddr = AW'(i_rotor_sel) * AW'(LETTERS) + AW'(i_position);
    assign w_rev_waddr = AW'(i_rotor_sel) * AW'(LETTERS) + AW'(i_entry_value);

    // Plugboard resets to identity; reflector is undefined until loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LETTERS; i++) begin
                r_plug[i] <= LETTER_W'(i);
            end
        end else if (w_plug_we) begin
            r_plug[i_position]    <= i_entry_value;
            r_plug[i_entry_value] <= i_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_refl_we) begin
            r_refl[i_position]    <= i_entry_value;
            r_refl[i_entry_value] <= i_position;
        end
    end

    ecr_rotor_state #(
        .MAX_ROTORS (MAX_ROTORS)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_rs_load),
        .i_step_en   (w_step_en),
        .i_step_idx  (w_step_idx),
        .i_rd_idx    (w_rd_idx),
        .o_offset    (w_offset),
        .o_notch_hit (w_hit)
    );

    ecr_rotor_mem #(
        .MAX_ROTORS (MAX_ROTORS)
    ) u_mem (
        .i_clk       (i_clk),
        .i_we        (w_wire_we),
        .i_fwd_waddr (w_fwd_waddr),
        .i_fwd_wdata (i_entry_value),
        .i_rev_waddr (w_rev_waddr),
        .i_rev_wdata (i_position),
        .i_re        (w_iss),
        .i_raddr     (w_raddr),
        .o_fwd_rdata (w_fwd_rdata),
        .o_rev_rdata (w_rev_rdata)
    );

    // Letter leaving the rotor whose read just returned
    assign w_rdata    = (r_dir == DIR_REV) ? w_rev_rdata : w_fwd_rdata;
    assign w_x_t      = letter_sub(w_rdata, r_k);
    assign w_plug_idx = (r_state == ST_PLUG) ? letter_mod(r_x) : w_x_t;
    assign w_plug_out = r_plug[w_plug_idx];
    assign w_rd_idx   = (r_state == ST_CASC) ? r_j : w_iss_idx;
    assign w_raddr    = AW'(w_iss_idx) * AW'(LETTERS) + AW'(letter_add(w_iss_x, w_offset));

    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_j          = r_j;
        n_k          = r_k;
        n_dir        = r_dir;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_letter = r_out_letter;
        w_iss        = 1'b0;
        w_iss_idx    = r_j;
        w_iss_x      = w_x_t;
        w_iss_dir    = r_dir;
        w_step_en    = 1'b0;
        w_step_idx   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_kind == KIND_ENC) begin
                    n_x     = i_position;
                    n_state = ST_PLUG;
                end
            end
            ST_PLUG: begin
                // plugboard in, then step the fast rotor
                n_x       = w_plug_out;
                w_step_en = 1'b1;
                w_step_idx = '0;
                n_j       = '0;
                n_state   = (w_last_idx == '0) ? ST_ISSUE : ST_CASC;
            end
            ST_CASC: begin
                // rotor j sits on a notch: carry into rotor j+1
                w_step_en  = w_hit;
                w_step_idx = r_j + IDX_W'(1);
                if (r_j + IDX_W'(1) == w_last_idx) begin
                    n_state = ST_ISSUE;
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            ST_ISSUE: begin
                w_iss     = 1'b1;
                w_iss_idx = '0;
                w_iss_x   = r_x;
                w_iss_dir = DIR_FWD;
                n_state   = ST_PASS;
            end
            ST_PASS: begin
                if (r_dir == DIR_FWD) begin
                    w_iss = 1'b1;
                    if (r_j == w_last_idx) begin
                        // turn around at the reflector
                        w_iss_idx = r_j;
                        w_iss_x   = r_refl[w_x_t];
                        w_iss_dir = DIR_REV;
                    end else begin
                        w_iss_idx = r_j + IDX_W'(1);
                        w_iss_dir = DIR_FWD;
                    end
                end else if (r_j != '0) begin
                    w_iss     = 1'b1;
                    w_iss_idx = r_j - IDX_W'(1);
                    w_iss_dir = DIR_REV;
                end else if (!r_out_valid || i_out_ready) begin
                    // plugboard out; hold here while the result register is full
                    n_out_valid  = 1'b1;
                    n_out_letter = w_plug_out;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (w_iss) begin
            n_j   = w_iss_idx;
            n_k   = w_offset;
            n_dir = w_iss_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_rotor_count <= CNT_W'(1);
            r_dir         <= DIR_FWD;
            r_j           <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_dir       <= n_dir;
            r_j         <= n_j;
            if (i_cfg_we) begin
                r_rotor_count <= i_cfg_wdata;
            end
        end
        r_x          <= n_x;
        r_k          <= n_k;
        r_out_letter <= n_out_letter;
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cipher_letter = r_out_letter;

`ifndef ASSERT_OFF
    // a result only appears at the end of the rotor pass
    a_result_from_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_PASS)
        else $error("result raised outside the rotor pass");

    // an accepted letter always starts with the plugboard
    a_enc_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind == KIND_ENC) |=> r_state == ST_PLUG)
        else $error("encipher item did not start");

    // the pass never walks past the last rotor in use
    a_rotor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS) |-> r_j <= w_last_idx)
        else $error("rotor index beyond rotors in use");

    // rotor offsets stay letters
    a_offset_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS) |-> r_k < LETTER_W'(LETTERS))
        else $error("rotor offset out of range");
`endif

endmodule
